// ===== design/tcw_pkg.sv =====
`timescale 1ns / 1ps
// tcw_pkg: field widths, character codes and action codes of the text console writer
// no dependencies

package tcw_pkg;

  localparam int ACTION_W = 2;
  localparam int CHAR_W   = 8;
  localparam int COLOR_W  = 8;
  localparam int ROW_W    = 5;
  localparam int COL_W    = 7;
  localparam int CELL_W   = CHAR_W + COLOR_W;

  localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0]  BLANK_CODE   = 8'd32;
  localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'd7;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUT   = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

endpackage

// ===== design/tcw_if.sv =====
`timescale 1ns / 1ps
// tcw_in_if and tcw_out_if: valid/ready channels of the text console writer
// depends on tcw_pkg

interface tcw_in_if;
  import tcw_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [CHAR_W-1:0]   char_code;
  logic [COLOR_W-1:0]  cell_color;
  logic [ROW_W-1:0]    target_row;
  logic [COL_W-1:0]    target_column;

  modport source (output valid, action, char_code, cell_color, target_row, target_column,
                  input ready);
  modport sink (input valid, action, char_code, cell_color, target_row, target_column,
                output ready);
endinterface

interface tcw_out_if;
  import tcw_pkg::*;

  logic               valid;
  logic               ready;
  logic [CELL_W-1:0]  cell_entry;
  logic [ROW_W-1:0]   cursor_row;
  logic [COL_W-1:0]   cursor_column;
  logic               did_scroll;

  modport source (output valid, cell_entry, cursor_row, cursor_column, did_scroll,
                  input ready);
  modport sink (input valid, cell_entry, cursor_row, cursor_column, did_scroll,
                output ready);
endinterface

// ===== design/tcw_screen_ram.sv =====
`timescale 1ns / 1ps
// tcw_screen_ram: single-port screen memory, one access per cycle, registered read data
// depends on tcw_pkg

module tcw_screen_ram #(
  parameter int  DEPTH = 2000,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic                      re,
  input  logic [AW-1:0]             addr,
  input  logic [tcw_pkg::CELL_W-1:0] wdata,
  output logic [tcw_pkg::CELL_W-1:0] rdata
);
  import tcw_pkg::*;

  logic [CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== design/tcw_addr_map.sv =====
`timescale 1ns / 1ps
// tcw_addr_map: logical row/column to memory address through the rotating top-row pointer
// no package dependencies

module tcw_addr_map #(
  parameter int  SCREEN_ROWS    = 25,
  parameter int  SCREEN_COLUMNS = 80,
  localparam int RW = $clog2(SCREEN_ROWS),
  localparam int CW = $clog2(SCREEN_COLUMNS),
  localparam int AW = $clog2(SCREEN_ROWS * SCREEN_COLUMNS)
) (
  input  logic [RW-1:0] top_row,
  input  logic [RW-1:0] row,
  input  logic [CW-1:0] col,
  output logic [AW-1:0] addr
);

  logic [RW:0]   row_sum;
  logic [RW-1:0] phys_row;

  // row + top stays below twice the row count, so one compare and subtract wraps it
  always_comb begin
    row_sum = {1'b0, row} + {1'b0, top_row};
    if (row_sum >= (RW+1)'(SCREEN_ROWS)) begin
      phys_row = RW'(row_sum - (RW+1)'(SCREEN_ROWS));
    end else begin
      phys_row = RW'(row_sum);
    end
    addr = AW'(phys_row) * AW'(SCREEN_COLUMNS) + AW'(col);
  end

endmodule

// ===== design/text_console_writer_unit.sv =====
`timescale 1ns / 1ps
// text_console_writer_unit: top level of the text console writer
// depends on tcw_pkg, tcw_if, tcw_screen_ram, tcw_addr_map

// The screen lives in one single-port memory of SCREEN_ROWS x SCREEN_COLUMNS cells,
// addressed through a rotating top-row pointer, so a scroll never copies rows: it
// advances the pointer and blanks the row that becomes the bottom one. After reset the
// block runs a clearing pass over all SCREEN_ROWS * SCREEN_COLUMNS cells (2000 at 80x25),
// writing one blank cell per cycle, and takes no input item meanwhile; text_color
// writes are taken at any time. One item is worked on at a time, and the memory port
// sets the states it passes: a printed character, newline, cell write or unused action
// goes from idle straight to done, an on-screen cell read passes a read state for the
// registered memory read, and any item that scrolls passes the bottom-row blanking sweep.
// Results sit in an output register, so a finished result waiting for its transfer
// does not hold back the work on that item; the next item is taken once it is loaded.

module text_console_writer_unit #(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS    = 25
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [tcw_pkg::COLOR_W-1:0] cfg_wdata,
  tcw_in_if.sink                     in_ch,
  tcw_out_if.source                  out_ch
);
  import tcw_pkg::*;

  localparam int CELLS = SCREEN_ROWS * SCREEN_COLUMNS;
  localparam int RW    = $clog2(SCREEN_ROWS);
  localparam int CW    = $clog2(SCREEN_COLUMNS);
  localparam int AW    = $clog2(CELLS);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_BLANK,
    ST_DONE
  } state_t;

  // control state
  state_t        state;
  logic [AW-1:0] clr_addr;
  logic [RW-1:0] cur_row;
  logic [CW-1:0] cur_col;
  logic [RW-1:0] top_row;
  logic [CW-1:0] blank_col;
  logic          out_valid;

  // per-item payload
  logic [CELL_W-1:0] entry;
  logic              scrolled;
  logic [CELL_W-1:0] out_entry;
  logic [ROW_W-1:0]  out_row;
  logic [COL_W-1:0]  out_col;
  logic              out_scroll;

  // configured attribute byte
  logic [COLOR_W-1:0] text_color;

  // memory port
  logic              mem_we;
  logic              mem_re;
  logic [AW-1:0]     mem_addr;
  logic [CELL_W-1:0] mem_wdata;
  logic [CELL_W-1:0] mem_rdata;

  // address mapping
  logic [RW-1:0] map_row;
  logic [CW-1:0] map_col;
  logic [AW-1:0] map_addr;

  // decoded input
  logic    accept;
  action_t act;
  logic    target_ok;
  logic    is_newline;
  logic    at_last_col;
  logic    at_last_row;
  logic    out_free;

  assign in_ch.ready = (state == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign act         = action_t'(in_ch.action);
  assign target_ok   = (32'(in_ch.target_row) < 32'(SCREEN_ROWS)) &&
                       (32'(in_ch.target_column) < 32'(SCREEN_COLUMNS));
  assign is_newline  = (in_ch.char_code == NEWLINE_CODE);
  assign at_last_col = (cur_col == CW'(SCREEN_COLUMNS - 1));
  assign at_last_row = (cur_row == RW'(SCREEN_ROWS - 1));
  assign out_free    = !out_valid || out_ch.ready;

  assign out_ch.valid         = out_valid;
  assign out_ch.cell_entry    = out_entry;
  assign out_ch.cursor_row    = out_row;
  assign out_ch.cursor_column = out_col;
  assign out_ch.did_scroll    = out_scroll;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= RESET_COLOR;
    end else if (cfg_we) begin
      text_color <= cfg_wdata;
    end
  end

  // the blanking sweep runs after the pointer has advanced, so the last logical row
  // lands on the old top row
  always_comb begin
    if (state == ST_BLANK) begin
      map_row = RW'(SCREEN_ROWS - 1);
      map_col = blank_col;
    end else if (act == ACT_PUT) begin
      map_row = cur_row;
      map_col = cur_col;
    end else begin
      map_row = RW'(in_ch.target_row);
      map_col = CW'(in_ch.target_column);
    end
  end

  tcw_addr_map #(
    .SCREEN_ROWS    (SCREEN_ROWS),
    .SCREEN_COLUMNS (SCREEN_COLUMNS)
  ) u_addr_map (
    .top_row (top_row),
    .row     (map_row),
    .col     (map_col),
    .addr    (map_addr)
  );

  // memory request
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = map_addr;
    mem_wdata = {text_color, in_ch.char_code};
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_addr;
        mem_wdata = {RESET_COLOR, BLANK_CODE};
      end
      ST_BLANK: begin
        mem_we    = 1'b1;
        mem_wdata = {text_color, BLANK_CODE};
      end
      ST_IDLE: begin
        if (accept) begin
          case (act)
            ACT_PUT: mem_we = !is_newline;
            ACT_WRITE: begin
              mem_we    = target_ok;
              mem_wdata = {in_ch.cell_color, in_ch.char_code};
            end
            ACT_READ: mem_re = target_ok;
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  tcw_screen_ram #(
    .DEPTH (CELLS)
  ) u_screen_ram (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      cur_row   <= '0;
      cur_col   <= '0;
      top_row   <= '0;
      blank_col <= '0;
      out_valid <= 1'b0;
    end else begin
      // a waiting result leaves on its transfer; in ST_DONE a new one replaces it below
      if (out_ch.ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          if (clr_addr == AW'(CELLS - 1)) begin
            state <= ST_IDLE;
          end else begin
            clr_addr <= clr_addr + AW'(1);
          end
        end
        ST_IDLE: begin
          if (accept) begin
            entry    <= '0;
            scrolled <= (act == ACT_PUT) && (is_newline || at_last_col) && at_last_row;
            case (act)
              ACT_PUT: begin
                if (is_newline || at_last_col) begin
                  // move to the start of the next row, scrolling off the bottom
                  cur_col <= '0;
                  if (at_last_row) begin
                    top_row   <= (top_row == RW'(SCREEN_ROWS - 1)) ? '0 : top_row + RW'(1);
                    blank_col <= '0;
                    state     <= ST_BLANK;
                  end else begin
                    cur_row <= cur_row + RW'(1);
                    state   <= ST_DONE;
                  end
                end else begin
                  cur_col <= cur_col + CW'(1);
                  state   <= ST_DONE;
                end
              end
              ACT_READ: begin
                state <= target_ok ? ST_READ : ST_DONE;
              end
              default: state <= ST_DONE;
            endcase
          end
        end
        ST_READ: begin
          entry <= mem_rdata;
          state <= ST_DONE;
        end
        ST_BLANK: begin
          if (blank_col == CW'(SCREEN_COLUMNS - 1)) begin
            state <= ST_DONE;
          end else begin
            blank_col <= blank_col + CW'(1);
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_entry  <= entry;
            out_row    <= ROW_W'(cur_row);
            out_col    <= COL_W'(cur_col);
            out_scroll <= scrolled;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_CLEAR;
      endcase
    end
  end

  // a scrolled result always leaves the cursor on the bottom row
  a_scroll_bottom: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.did_scroll |-> out_ch.cursor_row == ROW_W'(SCREEN_ROWS - 1))
    else $error("scroll result with cursor off the bottom row");

  // the cursor column never leaves the screen
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    32'(cur_col) < 32'(SCREEN_COLUMNS))
    else $error("cursor column out of range");

  // the single port never reads and writes in the same cycle
  a_port_excl: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_re))
    else $error("memory read and write collide");

  // read data is taken only in the cycle after a read was issued
  a_read_lat: assert property (@(posedge clk) disable iff (rst)
    state == ST_READ |-> $past(mem_re))
    else $error("read data taken without a read");

  // every memory write stays inside the screen
  a_addr_range: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> 32'(mem_addr) < 32'(CELLS))
    else $error("memory write outside the screen");

endmodule

// ===== tb/sv/text_console_writer_unit_test.sv =====
`timescale 1ns / 1ps
// text_console_writer_unit_test: self-checking bench for the text console writer
// depends on tcw_pkg, tcw_if and the text_console_writer_unit design files

module text_console_writer_unit_test;
  import tcw_pkg::*;

  localparam int TXT_COLS = 80;
  localparam int TXT_ROWS = 25;
  localparam int TXT_CELLS = TXT_COLS * TXT_ROWS;
  // drain time after the last expected reply, to catch any straggling reply
  localparam int DRAIN_CYCLES = 200;

  // one command transfer and one reply transfer, at the block's field widths
  typedef struct packed {
    action_t            action;
    logic [CHAR_W-1:0]  char_code;
    logic [COLOR_W-1:0] cell_color;
    logic [ROW_W-1:0]   target_row;
    logic [COL_W-1:0]   target_column;
  } console_cmd_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_entry;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_column;
    logic              did_scroll;
  } console_reply_t;

  // directed table row: the reply is typed in only where it is obvious
  typedef struct {
    console_cmd_t   cmd;
    bit             typed;
    console_reply_t want;
  } directed_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [COLOR_W-1:0] cfg_wdata;

  tcw_in_if  cmd_ch ();
  tcw_out_if reply_ch ();

  text_console_writer_unit #(
    .SCREEN_COLUMNS(TXT_COLS),
    .SCREEN_ROWS   (TXT_ROWS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (cmd_ch),
    .out_ch   (reply_ch)
  );

  // shadow copy of the screen, the cursor and the text color
  logic [CELL_W-1:0]  shadow_screen [TXT_CELLS];
  int unsigned        shadow_row;
  int unsigned        shadow_col;
  logic [COLOR_W-1:0] shadow_color;

  console_reply_t expected_replies [$];
  directed_row_t  directed_rows [$];
  int             mismatch_count = 0;
  bit             calm_run = 1'b0;   // no idling on either side once set

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // screen predictor
  // ---------------------------------------------------------------------------

  function automatic void shadow_clear();
    int i;
    for (i = 0; i < TXT_CELLS; i++) shadow_screen[i] = {RESET_COLOR, BLANK_CODE};
    shadow_row   = 0;
    shadow_col   = 0;
    shadow_color = RESET_COLOR;
  endfunction

  // cursor to column 0 of the next row; past the bottom the screen moves up one row
  // and the freed bottom row is blanked in the current text color
  function automatic bit shadow_next_row();
    int i;
    shadow_col = 0;
    if (shadow_row + 1 >= TXT_ROWS) begin
      for (i = 0; i < (TXT_ROWS - 1) * TXT_COLS; i++)
        shadow_screen[i] = shadow_screen[i + TXT_COLS];
      for (i = 0; i < TXT_COLS; i++)
        shadow_screen[(TXT_ROWS - 1) * TXT_COLS + i] = {shadow_color, BLANK_CODE};
      shadow_row = TXT_ROWS - 1;
      return 1'b1;
    end
    shadow_row++;
    return 1'b0;
  endfunction

  function automatic console_reply_t apply_console_cmd(input console_cmd_t c);
    console_reply_t r;
    bit             on_screen;
    int             cell_index;
    r          = '0;
    on_screen  = (int'(c.target_row) < TXT_ROWS) && (int'(c.target_column) < TXT_COLS);
    cell_index = int'(c.target_row) * TXT_COLS + int'(c.target_column);
    case (c.action)
      ACT_PUT: begin
        if (c.char_code == NEWLINE_CODE) begin
          // newline only moves the cursor
          r.did_scroll = shadow_next_row();
        end else begin
          shadow_screen[shadow_row * TXT_COLS + shadow_col] = {shadow_color, c.char_code};
          shadow_col++;
          if (shadow_col >= TXT_COLS) r.did_scroll = shadow_next_row();
        end
      end
      ACT_WRITE: begin
        // writes off the screen are dropped
        if (on_screen) shadow_screen[cell_index] = {c.cell_color, c.char_code};
      end
      ACT_READ: begin
        // reads off the screen return zero
        if (on_screen) r.cell_entry = shadow_screen[cell_index];
      end
      default: begin
        // unused action code leaves everything alone
      end
    endcase
    r.cursor_row    = ROW_W'(shadow_row);
    r.cursor_column = COL_W'(shadow_col);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void add_row(input action_t a, input int ch, input int color,
                                  input int row, input int col, input bit typed = 1'b0,
                                  input int entry = 0, input int cur_row = 0,
                                  input int cur_col = 0);
    directed_row_t d;
    d.cmd.action              = a;
    d.cmd.char_code           = CHAR_W'(ch);
    d.cmd.cell_color          = COLOR_W'(color);
    d.cmd.target_row          = ROW_W'(row);
    d.cmd.target_column       = COL_W'(col);
    d.typed                   = typed;
    d.want.cell_entry         = CELL_W'(entry);
    d.want.cursor_row         = ROW_W'(cur_row);
    d.want.cursor_column      = COL_W'(cur_col);
    d.want.did_scroll         = 1'b0;
    directed_rows.push_back(d);
  endfunction

  // mostly printing and newlines so the cursor reaches the bottom and scrolls,
  // with cell writes, reads and unused action codes mixed in, some of them off the screen
  function automatic console_cmd_t random_console_cmd();
    console_cmd_t c;
    int           pick;
    pick            = $urandom_range(0, 99);
    c.char_code     = CHAR_W'($urandom_range(0, 255));
    c.cell_color    = COLOR_W'($urandom_range(0, 255));
    c.target_row    = ROW_W'($urandom_range(0, TXT_ROWS - 1));
    c.target_column = COL_W'($urandom_range(0, TXT_COLS - 1));
    if ($urandom_range(0, 7) == 0) begin
      c.target_row    = ROW_W'($urandom_range(0, 31));
      c.target_column = COL_W'($urandom_range(0, 127));
    end
    if (pick < 30) begin
      c.action    = ACT_PUT;
      c.char_code = NEWLINE_CODE;
    end else if (pick < 65) begin
      c.action = ACT_PUT;
    end else if (pick < 78) begin
      c.action = ACT_WRITE;
    end else if (pick < 95) begin
      c.action = ACT_READ;
      // half the reads land on the cursor row, where the printing goes
      if ($urandom_range(0, 1) == 0) c.target_row = ROW_W'(shadow_row);
    end else begin
      c.action = ACT_NONE;
    end
    return c;
  endfunction

  // one command transfer, optionally preceded by a random sender gap; called and
  // returns at a falling edge, with valid left high for a back-to-back next item
  task automatic send_console_cmd(input console_cmd_t c, input bit typed = 1'b0,
                                  input console_reply_t want = '0);
    console_reply_t predicted;
    if (!calm_run && $urandom_range(0, 4) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    cmd_ch.valid         <= 1'b1;
    cmd_ch.action        <= c.action;
    cmd_ch.char_code     <= c.char_code;
    cmd_ch.cell_color    <= c.cell_color;
    cmd_ch.target_row    <= c.target_row;
    cmd_ch.target_column <= c.target_column;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    // transfer taken: the shadow state always advances, even for a typed row
    predicted = apply_console_cmd(c);
    expected_replies.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  task automatic send_long_line();
    console_cmd_t c;
    int           k;
    int           len;
    len = $urandom_range(TXT_COLS - 2, TXT_COLS + 2);
    for (k = 0; k < len; k++) begin
      c.action = ACT_PUT;
      do c.char_code = CHAR_W'($urandom_range(0, 255));
      while (c.char_code == NEWLINE_CODE);
      c.cell_color    = COLOR_W'($urandom_range(0, 255));
      c.target_row    = ROW_W'($urandom_range(0, 31));
      c.target_column = COL_W'($urandom_range(0, 127));
      send_console_cmd(c);
    end
  endtask

  // ---------------------------------------------------------------------------
  // reply side: random ready bursts, none in the calm part
  // ---------------------------------------------------------------------------

  initial begin
    reply_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (!calm_run && $urandom_range(0, 2) == 0) begin
        reply_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end
      reply_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(negedge clk);
    end
  end

  // every reply transfer is checked field by field against the oldest expectation
  always @(posedge clk) begin
    console_reply_t want;
    if (!rst && reply_ch.valid && reply_ch.ready) begin
      if (expected_replies.size() == 0) begin
        mismatch_count++;
        $display("%0t: reply with nothing pending: expected none, actual %h/%0d/%0d/%0d",
                 $realtime, reply_ch.cell_entry, reply_ch.cursor_row,
                 reply_ch.cursor_column, reply_ch.did_scroll);
      end else begin
        want = expected_replies.pop_front();
        if (reply_ch.cell_entry !== want.cell_entry) begin
          mismatch_count++;
          $display("%0t: cell_entry expected %h actual %h",
                   $realtime, want.cell_entry, reply_ch.cell_entry);
        end
        if (reply_ch.cursor_row !== want.cursor_row) begin
          mismatch_count++;
          $display("%0t: cursor_row expected %0d actual %0d",
                   $realtime, want.cursor_row, reply_ch.cursor_row);
        end
        if (reply_ch.cursor_column !== want.cursor_column) begin
          mismatch_count++;
          $display("%0t: cursor_column expected %0d actual %0d",
                   $realtime, want.cursor_column, reply_ch.cursor_column);
        end
        if (reply_ch.did_scroll !== want.did_scroll) begin
          mismatch_count++;
          $display("%0t: did_scroll expected %0d actual %0d",
                   $realtime, want.did_scroll, reply_ch.did_scroll);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    int           phase;
    int           n;
    int           long_at;
    logic [7:0]   new_color;

    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_wdata            = '0;
    cmd_ch.valid         = 1'b0;
    cmd_ch.action        = '0;
    cmd_ch.char_code     = '0;
    cmd_ch.cell_color    = '0;
    cmd_ch.target_row    = '0;
    cmd_ch.target_column = '0;
    shadow_clear();

    // directed table, walked in order right after reset (grey on black)
    add_row(ACT_READ,  0,    0,    0,  0,   1'b1, 16'h0720, 0, 0);  // top left blank
    add_row(ACT_READ,  0,    0,    24, 79,  1'b1, 16'h0720, 0, 0);  // bottom right blank
    add_row(ACT_READ,  0,    0,    31, 0,   1'b1, 0,        0, 0);  // row off the screen
    add_row(ACT_READ,  0,    0,    0,  127, 1'b1, 0,        0, 0);  // column off the screen
    add_row(ACT_READ,  0,    0,    25, 80,  1'b1, 0,        0, 0);  // just past both edges
    add_row(ACT_NONE,  255,  255,  31, 127, 1'b1, 0,        0, 0);  // unused action code
    add_row(ACT_WRITE, 8'h41, 255, 0,  0,   1'b1, 0,        0, 0);
    add_row(ACT_READ,  0,    0,    0,  0,   1'b1, 16'hFF41, 0, 0);
    add_row(ACT_WRITE, 8'h55, 8'hAA, 25, 0, 1'b1, 0,        0, 0);  // dropped write
    add_row(ACT_WRITE, 8'h55, 8'hAA, 0, 80, 1'b1, 0,        0, 0);  // dropped write
    add_row(ACT_WRITE, 255,  0,    24, 79,  1'b1, 0,        0, 0);
    add_row(ACT_READ,  0,    0,    24, 79,  1'b1, 16'h00FF, 0, 0);
    add_row(ACT_PUT,   0,    0,    0,  0,   1'b1, 0,        0, 1);  // lowest char code
    add_row(ACT_PUT,   255,  255,  31, 127, 1'b1, 0,        0, 2);  // highest char code
    add_row(ACT_PUT,   NEWLINE_CODE, 0, 0, 0, 1'b1, 0,      1, 0);
    add_row(ACT_READ,  0,    0,    0,  0);
    add_row(ACT_READ,  0,    0,    0,  1);
    add_row(ACT_READ,  0,    0,    0,  2);   // newline left this cell alone
    add_row(ACT_PUT,   8'h5A, 0,   0,  0);
    add_row(ACT_READ,  0,    0,    1,  0);
    add_row(ACT_WRITE, 255,  255,  31, 127);
    add_row(ACT_READ,  255,  255,  1,  79);

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // the block clears its screen first; the handshake simply waits for it
    foreach (directed_rows[i])
      send_console_cmd(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);

    for (phase = 0; phase < 4; phase++) begin
      if (phase > 0) begin
        // sender holds off until the block has returned every reply, then recolors
        cmd_ch.valid <= 1'b0;
        while (expected_replies.size() != 0) @(negedge clk);
        case (phase)
          1:       new_color = 8'h00;
          2:       new_color = 8'hFF;
          default: new_color = 8'($urandom_range(1, 254));
        endcase
        if (phase == 3) calm_run = 1'b1;
        cfg_we    <= 1'b1;
        cfg_wdata <= new_color;
        @(negedge clk);
        cfg_we       <= 1'b0;
        shadow_color  = new_color;
      end
      long_at = $urandom_range(0, 39);
      for (n = 0; n < 40; n++) begin
        // a line of TXT_COLS - 2 to TXT_COLS + 2 characters can force wraps, and a scroll from a wrap
        if (phase % 2 == 1 && n == long_at) send_long_line();
        send_console_cmd(random_console_cmd());
      end
    end

    cmd_ch.valid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_replies.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== text_console_writer_unit.f =====
design/tcw_pkg.sv
design/tcw_if.sv
design/tcw_screen_ram.sv
design/tcw_addr_map.sv
design/text_console_writer_unit.sv
tb/sv/text_console_writer_unit_test.sv
